// File: rtl/modem7_filename_receiver_defines.svh
// Assertion helpers used by the RTL core (m7fn_core.sv).
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef MODEM7_FILENAME_RECEIVER_DEFINES_SVH
`define MODEM7_FILENAME_RECEIVER_DEFINES_SVH

// Same-cycle implication.
`define M7FN_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("m7fn: same-cycle check failed");

// Next-cycle implication.
`define M7FN_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("m7fn: next-cycle check failed");

`endif

// File: rtl/m7fn_pkg.sv
`default_nettype none

package m7fn_pkg;

  localparam int M7FN_NAME_CAPACITY = 16;

  // Commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Control bytes
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_SUB = 8'h1A;
  localparam logic [7:0] B_U   = 8'h75;

  // Status codes
  localparam logic [2:0] ST_BUSY = 3'd0;
  localparam logic [2:0] ST_OK   = 3'd1;
  localparam logic [2:0] ST_EOB  = 3'd2;
  localparam logic [2:0] ST_FERR = 3'd3;
  localparam logic [2:0] ST_CARR = 3'd4;

  // Register indexes
  localparam logic [1:0] CFG_MAX_TRIES  = 2'd0;
  localparam logic [1:0] CFG_ACK_WAIT   = 2'd1;
  localparam logic [1:0] CFG_CHAR_WAIT  = 2'd2;

  localparam logic [7:0]  RST_MAX_TRIES = 8'd10;
  localparam logic [15:0] RST_WAIT      = 16'd1000;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic       carrier;
  } m7fn_in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       name_valid;
    logic [7:0] name_char;
    logic [3:0] name_index;
    logic       name_overflow;
    logic [2:0] status;
  } m7fn_out_t;

  typedef struct packed {
    logic [7:0]  max_tries;
    logic [15:0] ack_wait_ticks;
    logic [15:0] char_wait_ticks;
  } m7fn_cfg_t;

endpackage

`default_nettype wire

// File: rtl/m7fn_core.sv
`default_nettype none

`include "modem7_filename_receiver_defines.svh"

module m7fn_core
  import m7fn_pkg::*;
#(
  parameter int NAME_CAPACITY = M7FN_NAME_CAPACITY
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step,
  input  wire m7fn_in_t  in_data,
  input  wire m7fn_cfg_t cfg,
  output m7fn_out_t      res
);

  localparam int CntW = $clog2(NAME_CAPACITY + 1);
  localparam logic [CntW-1:0] CapVal = CntW'(NAME_CAPACITY);

  typedef enum logic [1:0] {PH_IDLE, PH_ACK, PH_CHAR, PH_OKCK} phase_t;

  phase_t          phase_r, phase_nxt;
  logic [7:0]      tries_r, tries_nxt;
  logic [15:0]     timer_r, timer_nxt;
  logic [7:0]      check_r, check_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [2:0]      final_r, final_nxt;

  logic [7:0]  tries_base;
  logic        nak_ok;
  logic        timeout;
  logic [15:0] timer_dec;

  always_comb begin
    tries_base = (in_data.command == CMD_START) ? 8'd0 : tries_r;
    nak_ok     = tries_base < cfg.max_tries;
    timeout    = timer_r <= 16'd1;
    timer_dec  = timeout ? 16'd0 : timer_r - 16'd1;
  end

  always_comb begin
    logic do_nak;
    do_nak    = 1'b0;
    phase_nxt = phase_r;
    tries_nxt = tries_r;
    timer_nxt = timer_r;
    check_nxt = check_r;
    count_nxt = count_r;
    final_nxt = final_r;
    res       = '0;

    unique case (in_data.command)
      CMD_START: begin
        tries_nxt = 8'd0;
        final_nxt = ST_BUSY;
        do_nak    = 1'b1;
      end
      CMD_BYTE: begin
        unique case (phase_r)
          PH_ACK: begin
            if (in_data.rx_byte == B_ACK) begin
              phase_nxt = PH_CHAR;
              timer_nxt = cfg.char_wait_ticks;
            end else if (in_data.rx_byte == B_EOT) begin
              phase_nxt = PH_IDLE;
              final_nxt = ST_EOB;
            end
          end
          PH_CHAR: begin
            if (in_data.rx_byte == B_EOT) begin
              phase_nxt = PH_IDLE;
              final_nxt = ST_OK;
            end else if (in_data.rx_byte == B_SUB) begin
              res.tx_valid = 1'b1;
              res.tx_byte  = B_SUB + check_r;
              phase_nxt    = PH_OKCK;
              timer_nxt    = cfg.char_wait_ticks;
            end else if (in_data.rx_byte == B_U) begin
              do_nak = 1'b1;
            end else begin
              res.name_valid = 1'b1;
              res.name_char  = in_data.rx_byte;
              if (count_r >= CapVal) begin
                res.name_overflow = 1'b1;
              end else begin
                res.name_index = count_r[3:0];
                count_nxt      = count_r + 1'b1;
              end
              check_nxt    = check_r + in_data.rx_byte;
              res.tx_valid = 1'b1;
              res.tx_byte  = B_ACK;
              timer_nxt    = cfg.char_wait_ticks;
            end
          end
          PH_OKCK: begin
            if (in_data.rx_byte == B_ACK) begin
              phase_nxt = PH_IDLE;
              final_nxt = ST_OK;
            end else begin
              do_nak = 1'b1;
            end
          end
          PH_IDLE: ;
          default: ;
        endcase
      end
      CMD_TICK: begin
        if (phase_r == PH_ACK && !in_data.carrier) begin
          phase_nxt = PH_IDLE;
          final_nxt = ST_CARR;
        end else if (phase_r != PH_IDLE) begin
          timer_nxt = timer_dec;
          do_nak    = timeout;
        end
      end
      default: ;
    endcase

    // Retry: either send NAK and rearm, or give up with a filename error.
    if (do_nak) begin
      if (nak_ok) begin
        count_nxt    = '0;
        check_nxt    = 8'd0;
        tries_nxt    = tries_base + 8'd1;
        timer_nxt    = cfg.ack_wait_ticks;
        phase_nxt    = PH_ACK;
        res.tx_valid = 1'b1;
        res.tx_byte  = B_NAK;
      end else begin
        phase_nxt = PH_IDLE;
        final_nxt = ST_FERR;
      end
    end

    res.status = (phase_nxt == PH_IDLE) ? final_nxt : ST_BUSY;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tries_r <= 8'd0;
      timer_r <= 16'd0;
      check_r <= 8'd0;
      count_r <= '0;
      final_r <= ST_BUSY;
    end else if (step) begin
      phase_r <= phase_nxt;
      tries_r <= tries_nxt;
      timer_r <= timer_nxt;
      check_r <= check_nxt;
      count_r <= count_nxt;
      final_r <= final_nxt;
    end
  end

  `M7FN_ASSERT_IMP(a_name_acked, res.name_valid, res.tx_valid && res.tx_byte == B_ACK)
  `M7FN_ASSERT_IMP(a_ovf_unindexed, res.name_overflow, res.name_valid && res.name_index == 4'd0)
  `M7FN_ASSERT_IMP(a_tx_busy, res.tx_valid, res.status == ST_BUSY)
  `M7FN_ASSERT_IMP(a_count_cap, 1'b1, count_r <= CapVal)
  `M7FN_ASSERT_NXT(a_start_waits_ack,
    step && in_data.command == CMD_START && cfg.max_tries != 8'd0, phase_r == PH_ACK)

endmodule

`default_nettype wire

// File: rtl/modem7_filename_receiver.sv
// Modem7 batch filename receiver.
// Input channel (in_valid/in_ready/in_data) carries one request per event:
// a start command, a received serial byte, or one timer tick, plus the
// current carrier detect level. Every accepted request yields exactly one
// result on the output channel (out_valid/out_ready/out_data): a byte to
// transmit (NAK, ACK or checksum) when tx_valid is set, a delivered filename
// byte with its index when name_valid is set, and the exchange status.
// The state update and the result are computed in the cycle a request is
// accepted and the result sits in the output register from the next cycle
// on. Throughput is one request per cycle while the output is drained;
// in_ready is high whenever the output register is empty or is being drained.
// If the receiver stalls, the result is held and at most that one result is
// buffered; in_ready drops until it is taken.
// Registers written through cfg_we/cfg_index/cfg_wdata: index 0 retry limit,
// 1 ACK wait in ticks, 2 character wait in ticks. Write only while idle.
// Synchronous reset restores retry limit 10, both waits 1000, idle phase and
// busy status, and empties the output register.
`default_nettype none

module modem7_filename_receiver
  import m7fn_pkg::*;
#(
  parameter int NAME_CAPACITY = M7FN_NAME_CAPACITY
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire m7fn_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output m7fn_out_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  m7fn_cfg_t cfg_r;
  logic      out_valid_r;
  m7fn_out_t out_data_r;
  m7fn_out_t res;
  logic      step;

  assign in_ready  = !out_valid_r || out_ready;
  assign step      = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  m7fn_core #(
    .NAME_CAPACITY(NAME_CAPACITY)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .in_data(in_data),
    .cfg    (cfg_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_tries       <= RST_MAX_TRIES;
      cfg_r.ack_wait_ticks  <= RST_WAIT;
      cfg_r.char_wait_ticks <= RST_WAIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_TRIES: cfg_r.max_tries       <= cfg_wdata[7:0];
        CFG_ACK_WAIT:  cfg_r.ack_wait_ticks  <= cfg_wdata;
        CFG_CHAR_WAIT: cfg_r.char_wait_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load a fresh result on every accepted request; hold otherwise.
  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire

// File: dv/modem7_filename_receiver_tb.sv
`timescale 1ns / 1ps

module modem7_filename_receiver_tb;
  import m7fn_pkg::*;

  localparam logic [1:0] CMD_NONE  = 2'd3;
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_REQS    = 390;
  localparam int CFG_EVERY      = 130;

  typedef enum logic [1:0] {PH_IDLE, PH_WAIT_ACK, PH_NAME, PH_CHECK_ACK} phase_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  m7fn_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  m7fn_out_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  modem7_filename_receiver uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Receiver registers and state as the predictor sees them
  logic [7:0]  max_tries_q = RST_MAX_TRIES;
  logic [15:0] ack_wait_q  = RST_WAIT;
  logic [15:0] char_wait_q = RST_WAIT;
  phase_t      phase_q     = PH_IDLE;
  logic [7:0]  tries_q     = '0;
  logic [15:0] timer_q     = '0;
  logic [7:0]  sum_q       = '0;
  int          name_cnt_q  = 0;
  logic [2:0]  final_q     = ST_BUSY;

  m7fn_out_t reply_q[$];
  int snd_idle_pct = 36;
  int rcv_idle_pct = 66;
  int mismatches   = 0;
  int live_reqs    = 0;
  int reqs_taken   = 0;
  int replies_seen = 0;
  int reg_writes   = 0;
  int stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom_range(1));
  endfunction

  function automatic bit issue_nak();
    if (tries_q >= max_tries_q) begin
      phase_q = PH_IDLE;
      final_q = ST_FERR;
      return 1'b0;
    end
    name_cnt_q = 0;
    sum_q      = '0;
    tries_q    = tries_q + 8'd1;
    timer_q    = ack_wait_q;
    phase_q    = PH_WAIT_ACK;
    return 1'b1;
  endfunction

  function automatic bit tick_expired();
    if (timer_q <= 16'd1) begin
      timer_q = '0;
      return 1'b1;
    end
    timer_q = timer_q - 16'd1;
    return 1'b0;
  endfunction

  function automatic m7fn_out_t predict_reply(m7fn_in_t req);
    m7fn_out_t r;
    bit        nak;
    r   = '0;
    nak = 1'b0;
    case (req.command)
      CMD_START: begin
        tries_q = '0;
        final_q = ST_BUSY;
        nak = issue_nak();
      end
      CMD_BYTE: begin
        case (phase_q)
          PH_WAIT_ACK: begin
            // anything but ACK or EOT is line noise here
            if (req.rx_byte == B_ACK) begin
              phase_q = PH_NAME;
              timer_q = char_wait_q;
            end else if (req.rx_byte == B_EOT) begin
              phase_q = PH_IDLE;
              final_q = ST_EOB;
            end
          end
          PH_NAME: begin
            if (req.rx_byte == B_EOT) begin
              phase_q = PH_IDLE;
              final_q = ST_OK;
            end else if (req.rx_byte == B_SUB) begin
              r.tx_valid = 1'b1;
              r.tx_byte  = B_SUB + sum_q;
              phase_q    = PH_CHECK_ACK;
              timer_q    = char_wait_q;
            end else if (req.rx_byte == B_U) begin
              nak = issue_nak();
            end else begin
              r.name_valid = 1'b1;
              r.name_char  = req.rx_byte;
              if (name_cnt_q >= M7FN_NAME_CAPACITY) begin
                r.name_overflow = 1'b1;
              end else begin
                r.name_index = name_cnt_q[3:0];
                name_cnt_q++;
              end
              sum_q      = sum_q + req.rx_byte;
              r.tx_valid = 1'b1;
              r.tx_byte  = B_ACK;
              timer_q    = char_wait_q;
            end
          end
          PH_CHECK_ACK: begin
            if (req.rx_byte == B_ACK) begin
              phase_q = PH_IDLE;
              final_q = ST_OK;
            end else begin
              nak = issue_nak();
            end
          end
          default: ;
        endcase
      end
      CMD_TICK: begin
        // carrier only matters while waiting for ACK or EOT
        if (phase_q == PH_WAIT_ACK && !req.carrier) begin
          phase_q = PH_IDLE;
          final_q = ST_CARR;
        end else if (phase_q != PH_IDLE) begin
          if (tick_expired()) nak = issue_nak();
        end
      end
      default: ;
    endcase
    if (nak) begin
      r.tx_valid = 1'b1;
      r.tx_byte  = B_NAK;
    end
    r.status = (phase_q == PH_IDLE) ? final_q : ST_BUSY;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Check replies first: one taken at this edge always belongs to an earlier request
  always @(posedge clk) begin
    m7fn_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        replies_seen++;
        if (reply_q.size() == 0) begin
          $error("reply with no request pending: %p", out_data);
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          check_field("tx_valid", want.tx_valid, out_data.tx_valid);
          check_field("tx_byte", want.tx_byte, out_data.tx_byte);
          check_field("name_valid", want.name_valid, out_data.name_valid);
          check_field("name_char", want.name_char, out_data.name_char);
          check_field("name_index", want.name_index, out_data.name_index);
          check_field("name_overflow", want.name_overflow, out_data.name_overflow);
          check_field("status", want.status, out_data.status);
        end
      end
      if (in_valid && in_ready) begin
        reqs_taken++;
        if (in_data.command == CMD_START || phase_q != PH_IDLE) live_reqs++;
        reply_q.push_back(predict_reply(in_data));
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else if (++stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_req(input logic [1:0] cmd, input logic [7:0] data, input logic car);
    m7fn_in_t req;
    req.command = cmd;
    req.rx_byte = data;
    req.carrier = car;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    // in_ready is settled by the falling edge; the request goes at the next rising one
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_req(CMD_TICK, rnd_byte(), ($urandom_range(99) >= 3));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (reply_q.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] tries, input logic [15:0] ack_w,
                            input logic [15:0] char_w);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_TRIES;
    cfg_wdata <= {8'($urandom), tries};
    @(posedge clk);
    cfg_index <= CFG_ACK_WAIT;
    cfg_wdata <= ack_w;
    @(posedge clk);
    cfg_index <= CFG_CHAR_WAIT;
    cfg_wdata <= char_w;
    @(posedge clk);
    // no register behind this index: the write must change nothing
    cfg_index <= CFG_SPARE;
    cfg_wdata <= 16'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    max_tries_q = tries;
    ack_wait_q  = ack_w;
    char_wait_q = char_w;
    reg_writes += 4;
  endtask

  function automatic logic [7:0] pick_tries();
    case ($urandom_range(9))
      0: return 8'd255;
      1: return 8'd1;
      2: return 8'd0;
      default: return 8'($urandom_range(2, 6));
    endcase
  endfunction

  function automatic logic [15:0] pick_wait();
    case ($urandom_range(9))
      0: return 16'hFFFF;
      1: return 16'd0;
      2: return 16'd1;
      3: return RST_WAIT;
      default: return 16'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [7:0] name_byte();
    logic [7:0] b;
    do b = rnd_byte(); while (b == B_EOT || b == B_SUB || b == B_U);
    return b;
  endfunction

  // One filename exchange: mostly well formed, sometimes cut short or answered badly
  task automatic run_session();
    int pick;
    int n_name;
    send_req(CMD_START, rnd_byte(), rnd_bit());
    send_ticks($urandom_range(0, 3));
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_req(CMD_BYTE, B_EOT, rnd_bit());
      return;
    end
    if (pick < 14) begin
      send_req(CMD_TICK, rnd_byte(), 1'b0);
      return;
    end
    if (pick < 20) send_req(CMD_BYTE, rnd_byte(), rnd_bit());
    if (pick < 26) send_ticks($urandom_range(1, 14));
    send_req(CMD_BYTE, B_ACK, rnd_bit());
    n_name = ($urandom_range(9) == 0) ? $urandom_range(16, 22) : $urandom_range(0, 12);
    repeat (n_name) begin
      if ($urandom_range(9) == 0) send_ticks($urandom_range(1, 3));
      send_req(CMD_BYTE, name_byte(), rnd_bit());
    end
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_req(CMD_BYTE, B_EOT, rnd_bit());
      return;
    end
    if (pick < 14) begin
      send_req(CMD_BYTE, B_U, rnd_bit());
      return;
    end
    if (pick < 20) begin
      send_ticks($urandom_range(1, 14));
      return;
    end
    send_req(CMD_BYTE, B_SUB, rnd_bit());
    pick = $urandom_range(99);
    if (pick < 75) send_req(CMD_BYTE, B_ACK, rnd_bit());
    else if (pick < 87) send_req(CMD_BYTE, rnd_byte(), rnd_bit());
    else send_ticks($urandom_range(1, 14));
  endtask

  task automatic test_idle_inputs();
    send_req(CMD_TICK, 8'h00, 1'b0);
    send_req(CMD_BYTE, B_ACK, 1'b1);
    send_req(CMD_NONE, 8'hFF, 1'b1);
  endtask

  task automatic test_directed_exchange();
    // full name with a stray byte, a tick and an unknown command while waiting
    send_req(CMD_START, 8'h00, 1'b1);
    send_req(CMD_BYTE, 8'h55, 1'b0);
    send_req(CMD_TICK, 8'hFF, 1'b1);
    send_req(CMD_NONE, 8'h00, 1'b0);
    send_req(CMD_BYTE, B_ACK, 1'b1);
    send_req(CMD_BYTE, 8'h00, 1'b1);
    send_req(CMD_BYTE, 8'hFF, 1'b0);
    send_req(CMD_BYTE, B_ACK, 1'b1);
    send_req(CMD_BYTE, B_SUB, 1'b1);
    send_req(CMD_BYTE, B_ACK, 1'b1);
    // end of batch
    send_req(CMD_START, 8'hAA, 1'b1);
    send_req(CMD_BYTE, B_EOT, 1'b1);
    // carrier drop while waiting for ACK
    send_req(CMD_START, 8'h00, 1'b1);
    send_req(CMD_TICK, 8'h00, 1'b0);
    // 'u' forces a new NAK; then EOT inside the name
    send_req(CMD_START, 8'h00, 1'b1);
    send_req(CMD_BYTE, B_ACK, 1'b1);
    send_req(CMD_BYTE, B_U, 1'b1);
    send_req(CMD_BYTE, B_ACK, 1'b1);
    send_req(CMD_BYTE, 8'h41, 1'b1);
    send_req(CMD_BYTE, B_EOT, 1'b1);
    // wrong answer to the checksum
    send_req(CMD_START, 8'h00, 1'b1);
    send_req(CMD_BYTE, B_ACK, 1'b1);
    send_req(CMD_BYTE, B_SUB, 1'b1);
    send_req(CMD_BYTE, B_NAK, 1'b1);
  endtask

  task automatic test_register_extremes();
    write_regs(8'd255, 16'hFFFF, 16'hFFFF);
    repeat (4) run_session();
    write_regs(8'd1, 16'd1, 16'd1);
    repeat (4) run_session();
    write_regs(8'd0, 16'd0, 16'd0);
    repeat (2) run_session();
    write_regs(8'd3, 16'd0, 16'd2);
    repeat (4) run_session();
  endtask

  task automatic test_random_traffic(input int snd_pct, input int rcv_pct);
    int goal;
    int next_cfg;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    goal     = live_reqs + RANDOM_REQS;
    next_cfg = live_reqs + CFG_EVERY;
    while (live_reqs < goal) begin
      if (live_reqs >= next_cfg) begin
        write_regs(pick_tries(), pick_wait(), pick_wait());
        next_cfg = live_reqs + CFG_EVERY;
      end
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 3))
          send_req(2'($urandom_range(3)), rnd_byte(), rnd_bit());
      end else begin
        run_session();
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_inputs();
    test_directed_exchange();
    test_register_extremes();
    test_random_traffic(36, 66);
    test_random_traffic(66, 36);
    test_random_traffic(0, 0);

    wait_idle();
    repeat (4) @(posedge clk);
    $display("Run: %0d requests, %0d replies checked, %0d register writes",
             reqs_taken, replies_seen, reg_writes);
    $display("Stalls on either side, none, and retry limits and waits from zero to full");
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: modem7_filename_receiver.f
+incdir+rtl
rtl/m7fn_pkg.sv
rtl/m7fn_core.sv
rtl/modem7_filename_receiver.sv
dv/modem7_filename_receiver_tb.sv
